>>> src/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, skipped while reset is high.
`define ASSERT_SYNC(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication built on the one above.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   `ASSERT_SYNC(label, clk, rst, (ante) |-> (cons), msg)

`endif

>>> src/cmm_pkg.sv
package cmm_pkg;

   localparam int DEF_MAX_DIM    = 8;
   localparam int DEF_DATA_WIDTH = 16;

   localparam int DIM_W      = 4;
   localparam int LEN_W      = 2 * DIM_W;
   localparam int PROD_W     = 35;
   localparam int IDX_W      = 3;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 4;
   localparam int RSP_TDATA_W = ((PROD_W + 2 * IDX_W + 7) / 8) * 8;

   localparam logic [DIM_W-1:0] RESET_DIM = 4'd4;

   localparam logic [CSR_ADDR_W-1:0] REG_ROWS_OF_A = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_COLS_OF_B = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_INNER_DIM = 2'd2;

   typedef struct packed {
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic             first;
      logic             lastk;
      logic             last_all;
   } tag_type;

   typedef struct packed {
      logic adv;
      logic busy;
   } mac_stat_type;

   // zero counts as one, anything above the maximum as the maximum
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input int max_dim);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (int'(v) > max_dim) begin
         r = DIM_W'(max_dim);
      end
      return r;
   endfunction

endpackage

>>> src/cmm_mac.sv
module cmm_mac #(
   parameter int DATA_WIDTH = cmm_pkg::DEF_DATA_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             op_valid,
   input  logic signed [DATA_WIDTH-1:0]     op_a,
   input  logic signed [DATA_WIDTH-1:0]     op_b,
   input  cmm_pkg::tag_type                 op_tag,
   output cmm_pkg::mac_stat_type            stat,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [cmm_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tlast
);

   localparam int PROD_W   = cmm_pkg::PROD_W;
   localparam int IDX_W    = cmm_pkg::IDX_W;
   localparam int RSP_W    = cmm_pkg::RSP_TDATA_W;
   localparam int MUL_W    = 2 * DATA_WIDTH;

   logic                     s2_valid_ff, s2_valid_in;
   cmm_pkg::tag_type         s2_tag_ff;
   logic signed [MUL_W-1:0]  prod_ff, prod_in;
   logic [PROD_W-1:0]        acc_ff, acc_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [PROD_W-1:0]        rsp_sum_ff;
   logic [IDX_W-1:0]         rsp_row_ff, rsp_col_ff;
   logic                     rsp_last_ff;
   logic [PROD_W-1:0]        sum;
   logic                     adv;
   logic                     emit;

   assign adv  = !(s2_valid_ff && s2_tag_ff.lastk) || !rsp_valid_ff || rsp_tready;
   assign emit = adv && s2_valid_ff && s2_tag_ff.lastk;
   assign sum  = (s2_tag_ff.first ? '0 : acc_ff) + PROD_W'(prod_ff);

   always_comb begin
      prod_in      = op_a * op_b;
      s2_valid_in  = s2_valid_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      if (adv) begin
         s2_valid_in = op_valid;
         if (s2_valid_ff) begin
            acc_in = sum;
         end
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (adv) begin
         prod_ff   <= prod_in;
         s2_tag_ff <= op_tag;
      end
      if (emit) begin
         rsp_sum_ff  <= sum;
         rsp_row_ff  <= s2_tag_ff.row;
         rsp_col_ff  <= s2_tag_ff.col;
         rsp_last_ff <= s2_tag_ff.last_all;
      end
   end

   assign stat.adv   = adv;
   assign stat.busy  = s2_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_col_ff, rsp_row_ff, rsp_sum_ff});
   assign rsp_tlast  = rsp_last_ff;

endmodule

>>> src/column_major_matrix_multiply.sv
// Column-major matrix multiply C = A * B in exact fixed point. Elements stream in one item
// per cycle, all of A then all of B, each column by column; A and B sit in two single-port
// RAMs. The item that completes B starts a burst: one multiply-accumulate unit reads one
// A/B pair per cycle, and input is held off (req_tready low) while the pairs are read and
// the MAC pipeline drains; with results taken at once, the last result appears in the cycle
// before input reopens. Results leave column by column, top to bottom, the final one with
// rsp_tlast. A stall on the result side stalls the MAC pipeline and lengthens the hold-off.
// A write to any of the three dimension registers restarts loading with the first element
// of A; write registers only while the block is idle.
module column_major_matrix_multiply #(
   parameter int MAX_DIM    = cmm_pkg::DEF_MAX_DIM,
   parameter int DATA_WIDTH = cmm_pkg::DEF_DATA_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [cmm_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  logic [cmm_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((DATA_WIDTH+7)/8)*8-1:0]      req_tdata,  // element_value
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [cmm_pkg::RSP_TDATA_W-1:0]      rsp_tdata,  // product_value, row_index, col_index
   output logic                                 rsp_tlast   // last_result
);

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DIM_W  = cmm_pkg::DIM_W;
   localparam int LEN_W  = cmm_pkg::LEN_W;
   localparam int IDX_W  = cmm_pkg::IDX_W;
   localparam int LW     = (ADDR_W > LEN_W) ? ADDR_W : LEN_W;

   typedef enum logic [2:0] {
      ST_LOAD  = 3'b001,
      ST_ISSUE = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   state_type                state_ff, state_in;
   logic [DIM_W-1:0]         rows_ff, rows_in, cols_ff, cols_in, inner_ff, inner_in;
   logic                     in_b_ff, in_b_in;
   logic [LW-1:0]            load_addr_ff, load_addr_in;
   logic [DIM_W-1:0]         i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [ADDR_W-1:0]        a_ptr_ff, a_ptr_in, b_ptr_ff, b_ptr_in, b_base_ff, b_base_in;
   logic                     s1_valid_ff, s1_valid_in;
   cmm_pkg::tag_type         s1_tag_ff, s1_tag_in;
   logic signed [DATA_WIDTH-1:0] rd_a_ff, rd_b_ff;

   logic [DATA_WIDTH-1:0]    a_mem [DEPTH];
   logic [DATA_WIDTH-1:0]    b_mem [DEPTH];

   cmm_pkg::mac_stat_type    mac_stat;
   logic                     req_acc, wr_a, wr_b, issue;
   logic [LEN_W-1:0]         a_len, b_len;
   logic [LW-1:0]            a_end, b_end;
   logic                     k_last, i_last, j_last;
   logic [DIM_W-1:0]         dim_w;

   assign req_tready = (state_ff == ST_LOAD);
   assign req_acc    = req_tvalid && req_tready;
   assign wr_a       = req_acc && !in_b_ff;
   assign wr_b       = req_acc && in_b_ff;
   assign issue      = (state_ff == ST_ISSUE) && mac_stat.adv;

   assign a_len = LEN_W'(rows_ff) * LEN_W'(inner_ff);
   assign b_len = LEN_W'(inner_ff) * LEN_W'(cols_ff);
   assign a_end = LW'(a_len) - LW'(1);
   assign b_end = LW'(b_len) - LW'(1);

   assign k_last = (k_ff == inner_ff - DIM_W'(1));
   assign i_last = (i_ff == rows_ff - DIM_W'(1));
   assign j_last = (j_ff == cols_ff - DIM_W'(1));
   assign dim_w  = cmm_pkg::clamp_dim(csr_wdata, MAX_DIM);

   always_comb begin
      state_in     = state_ff;
      rows_in      = rows_ff;
      cols_in      = cols_ff;
      inner_in     = inner_ff;
      in_b_in      = in_b_ff;
      load_addr_in = load_addr_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      a_ptr_in     = a_ptr_ff;
      b_ptr_in     = b_ptr_ff;
      b_base_in    = b_base_ff;
      s1_valid_in  = s1_valid_ff;
      s1_tag_in    = s1_tag_ff;

      case (state_ff)
         ST_LOAD: begin
            if (req_acc) begin
               if (!in_b_ff) begin
                  if (load_addr_ff == a_end) begin
                     in_b_in      = 1'b1;
                     load_addr_in = '0;
                  end else begin
                     load_addr_in = load_addr_ff + LW'(1);
                  end
               end else if (load_addr_ff == b_end) begin
                  in_b_in      = 1'b0;
                  load_addr_in = '0;
                  state_in     = ST_ISSUE;
                  i_in         = '0;
                  j_in         = '0;
                  k_in         = '0;
                  a_ptr_in     = '0;
                  b_ptr_in     = '0;
                  b_base_in    = '0;
               end else begin
                  load_addr_in = load_addr_ff + LW'(1);
               end
            end
         end
         ST_ISSUE: begin
            if (issue) begin
               if (!k_last) begin
                  k_in     = k_ff + DIM_W'(1);
                  a_ptr_in = a_ptr_ff + ADDR_W'(rows_ff);
                  b_ptr_in = b_ptr_ff + ADDR_W'(1);
               end else begin
                  k_in = '0;
                  if (!i_last) begin
                     i_in     = i_ff + DIM_W'(1);
                     a_ptr_in = ADDR_W'(i_ff) + ADDR_W'(1);
                     b_ptr_in = b_base_ff;
                  end else begin
                     i_in      = '0;
                     a_ptr_in  = '0;
                     b_base_in = b_base_ff + ADDR_W'(inner_ff);
                     b_ptr_in  = b_base_ff + ADDR_W'(inner_ff);
                     if (j_last) begin
                        j_in     = '0;
                        state_in = ST_DRAIN;
                     end else begin
                        j_in = j_ff + DIM_W'(1);
                     end
                  end
               end
            end
         end
         ST_DRAIN: begin
            if (!s1_valid_ff && !mac_stat.busy) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase

      if (mac_stat.adv) begin
         s1_valid_in        = issue;
         s1_tag_in.row      = i_ff[IDX_W-1:0];
         s1_tag_in.col      = j_ff[IDX_W-1:0];
         s1_tag_in.first    = (k_ff == '0);
         s1_tag_in.lastk    = k_last;
         s1_tag_in.last_all = i_last && j_last;
      end

      // a dimension register write drops a partial load
      if (csr_we) begin
         case (csr_addr)
            cmm_pkg::REG_ROWS_OF_A: begin
               rows_in      = dim_w;
               in_b_in      = 1'b0;
               load_addr_in = '0;
            end
            cmm_pkg::REG_COLS_OF_B: begin
               cols_in      = dim_w;
               in_b_in      = 1'b0;
               load_addr_in = '0;
            end
            cmm_pkg::REG_INNER_DIM: begin
               inner_in     = dim_w;
               in_b_in      = 1'b0;
               load_addr_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         rows_ff      <= cmm_pkg::clamp_dim(cmm_pkg::RESET_DIM, MAX_DIM);
         cols_ff      <= cmm_pkg::clamp_dim(cmm_pkg::RESET_DIM, MAX_DIM);
         inner_ff     <= cmm_pkg::clamp_dim(cmm_pkg::RESET_DIM, MAX_DIM);
         in_b_ff      <= 1'b0;
         load_addr_ff <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         a_ptr_ff     <= '0;
         b_ptr_ff     <= '0;
         b_base_ff    <= '0;
         s1_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         inner_ff     <= inner_in;
         in_b_ff      <= in_b_in;
         load_addr_ff <= load_addr_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         a_ptr_ff     <= a_ptr_in;
         b_ptr_ff     <= b_ptr_in;
         b_base_ff    <= b_base_in;
         s1_valid_ff  <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_tag_ff <= s1_tag_in;
   end

   always_ff @(posedge clock) begin
      if (wr_a) begin
         a_mem[load_addr_ff[ADDR_W-1:0]] <= req_tdata[DATA_WIDTH-1:0];
      end
      if (issue) begin
         rd_a_ff <= a_mem[a_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_b) begin
         b_mem[load_addr_ff[ADDR_W-1:0]] <= req_tdata[DATA_WIDTH-1:0];
      end
      if (issue) begin
         rd_b_ff <= b_mem[b_ptr_ff];
      end
   end

   cmm_mac #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_mac (
      .clock      (clock),
      .reset      (reset),
      .op_valid   (s1_valid_ff),
      .op_a       (rd_a_ff),
      .op_b       (rd_b_ff),
      .op_tag     (s1_tag_ff),
      .stat       (mac_stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> src/cmm_checker.sv
`include "assert_macros.svh"

module cmm_checker #(
   parameter int MAX_DIM    = cmm_pkg::DEF_MAX_DIM,
   parameter int DATA_WIDTH = cmm_pkg::DEF_DATA_WIDTH
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 csr_we,
   input logic [cmm_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input logic [cmm_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input logic                                 req_tvalid,
   input logic                                 req_tready,
   input logic [((DATA_WIDTH+7)/8)*8-1:0]      req_tdata,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [cmm_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   input logic                                 rsp_tlast
);

   localparam int DIM_W  = cmm_pkg::DIM_W;
   localparam int IDX_W  = cmm_pkg::IDX_W;
   localparam int PROD_W = cmm_pkg::PROD_W;
   localparam int USED_W = PROD_W + 2 * IDX_W;
   localparam int RSP_W  = cmm_pkg::RSP_TDATA_W;

   logic [DIM_W-1:0] rows_ff, rows_in, cols_ff, cols_in;
   logic [IDX_W-1:0] row, col, row_end, col_end;
   logic             pad_zero;
   logic             req_seen;

   assign row      = rsp_tdata[PROD_W +: IDX_W];
   assign col      = rsp_tdata[PROD_W + IDX_W +: IDX_W];
   assign row_end  = IDX_W'(rows_ff - DIM_W'(1));
   assign col_end  = IDX_W'(cols_ff - DIM_W'(1));
   assign pad_zero = (rsp_tdata >> USED_W) == RSP_W'(0);
   assign req_seen = req_tvalid && req_tready && (req_tdata == req_tdata);

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_we && csr_addr == cmm_pkg::REG_ROWS_OF_A) begin
         rows_in = cmm_pkg::clamp_dim(csr_wdata, MAX_DIM);
      end
      if (csr_we && csr_addr == cmm_pkg::REG_COLS_OF_B) begin
         cols_in = cmm_pkg::clamp_dim(csr_wdata, MAX_DIM);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= cmm_pkg::clamp_dim(cmm_pkg::RESET_DIM, MAX_DIM);
         cols_ff <= cmm_pkg::clamp_dim(cmm_pkg::RESET_DIM, MAX_DIM);
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end
   end

   `ASSERT_SYNC(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "result changed while stalled")
   `ASSERT_IMPLY(a_last_pos, clock, reset, rsp_tvalid && rsp_tlast, row == row_end && col == col_end, "last item not at final row and column")
   `ASSERT_IMPLY(a_idx_range, clock, reset, rsp_tvalid, (DIM_W'(row) < rows_ff) && (DIM_W'(col) < cols_ff), "result index outside the matrix")
   `ASSERT_IMPLY(a_pad_zero, clock, reset, rsp_tvalid || req_seen, pad_zero, "result padding bits not zero")

endmodule

bind column_major_matrix_multiply cmm_checker #(
   .MAX_DIM    (MAX_DIM),
   .DATA_WIDTH (DATA_WIDTH)
) u_cmm_checker (.*);
